@@ sv/dcrq_pkg.sv @@
// Types, codes and helpers shared by the display character ring queue.
package dcrq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 128;

   localparam logic       CMD_PUSH        = 1'b0;
   localparam logic       CMD_POP         = 1'b1;
   localparam logic [7:0] NUL_BYTE        = 8'h00;
   localparam logic [7:0] HOME_BYTE       = 8'h0c;
   localparam logic [7:0] FIRST_PRINTABLE = 8'h20;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_HOME  = 2'd1,
      KIND_PRINT = 2'd2,
      KIND_CTRL  = 2'd3
   } kind_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic       push_taken;
      logic [7:0] char_out;
      kind_type   char_kind;
      logic [7:0] fill_level;
   } rsp_type;

   function automatic kind_type classify(input logic [7:0] c);
      kind_type k;
      if (c == NUL_BYTE) begin
         k = KIND_NONE;
      end else if (c == HOME_BYTE) begin
         k = KIND_HOME;
      end else if (c < FIRST_PRINTABLE) begin
         k = KIND_CTRL;
      end else begin
         k = KIND_PRINT;
      end
      return k;
   endfunction

endpackage

@@ sv/dcrq_store.sv @@
// Character store: one write port, one read port with registered read data.
module dcrq_store #(
   parameter int QUEUE_DEPTH = dcrq_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [QUEUE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/display_char_ring_queue.sv @@
// Top level of the display character ring queue: control, pointers and result beat.
//
//   channel   ports                     direction   handshake
//   request   start, busy, req_data     in          start & !busy
//   result    rsp_strobe, rsp_data      out         rsp_strobe, one cycle
//
// One beat per cycle; each result appears in the cycle after its request beat,
// the pop byte coming from the store's registered read port.
// Synchronous reset clears the read pointer, the count and the strobe;
// store contents are unknown until written. busy stays low; the receiver
// cannot stall, so every result is taken in its strobe cycle.
module display_char_ring_queue #(
   parameter int QUEUE_DEPTH = dcrq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dcrq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output dcrq_pkg::rsp_type rsp_data
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;

   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          valid_ff;
   logic          is_pop_ff, is_pop_in;
   logic          hit_ff, hit_in;
   logic          taken_ff, taken_in;
   logic [7:0]    fill_ff;

   logic          accept;
   logic          do_push;
   logic          do_pop;
   logic [SW-1:0] tail_sum;
   logic [SW-1:0] tail_wrap;
   logic [AW-1:0] wr_addr;
   logic [7:0]    rd_data;
   logic [7:0]    char_out;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign do_push = accept && (req_data.cmd == dcrq_pkg::CMD_PUSH)
                    && (count_ff < CW'(QUEUE_DEPTH))
                    && (req_data.char_in != dcrq_pkg::NUL_BYTE);
   assign do_pop  = accept && (req_data.cmd == dcrq_pkg::CMD_POP)
                    && (count_ff != '0);

   assign tail_sum  = SW'(rd_ptr_ff) + SW'(count_ff);
   assign tail_wrap = (tail_sum >= SW'(QUEUE_DEPTH)) ? tail_sum - SW'(QUEUE_DEPTH)
                                                     : tail_sum;
   assign wr_addr   = tail_wrap[AW-1:0];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         count_in = count_ff + CW'(1);
      end
      if (do_pop) begin
         count_in  = count_ff - CW'(1);
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      is_pop_in = (req_data.cmd == dcrq_pkg::CMD_POP);
      hit_in    = do_pop;
      taken_in  = do_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         valid_ff  <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         is_pop_ff <= is_pop_in;
         hit_ff    <= hit_in;
         taken_ff  <= taken_in;
         fill_ff   <= 8'(count_in);
      end
   end

   dcrq_store #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (do_push),
      .wr_addr(wr_addr),
      .wr_data(req_data.char_in),
      .rd_en  (do_pop),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

   assign char_out = hit_ff ? rd_data : dcrq_pkg::NUL_BYTE;

   assign rsp_strobe          = valid_ff;
   assign rsp_data.push_taken = taken_ff;
   assign rsp_data.char_out   = char_out;
   assign rsp_data.char_kind  = is_pop_ff ? dcrq_pkg::classify(char_out)
                                          : dcrq_pkg::KIND_NONE;
   assign rsp_data.fill_level = fill_ff;

endmodule
